FILE: hdl/yuvrgb_pkg.sv
// Shared types and constants for the YUV pixel pair to RGB converter.
// No dependencies; used by every module of the block.
`default_nettype none

package yuvrgb_pkg;

  // Width of a signed raw channel sum before scaling and saturation.
  localparam int unsigned RAW_W = 19;

  // Widths of the pixel fields.
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned PACK_W   = 24;
  localparam int unsigned WORD_W   = 16;

  // BT.601 limited-range coefficients.
  localparam logic signed [RAW_W-1:0] C_Y      = RAW_W'(298);
  localparam logic signed [RAW_W-1:0] C_RV     = RAW_W'(409);
  localparam logic signed [RAW_W-1:0] C_GU     = RAW_W'(100);
  localparam logic signed [RAW_W-1:0] C_GV     = RAW_W'(208);
  localparam logic signed [RAW_W-1:0] C_BU     = RAW_W'(516);
  localparam logic signed [RAW_W-1:0] C_ROUND  = RAW_W'(128);
  localparam logic signed [RAW_W-1:0] C_Y_OFS  = RAW_W'(16);

  // Raw channel sums of one pixel, as the lane registers them.
  typedef struct packed {
    logic signed [RAW_W-1:0] r;
    logic signed [RAW_W-1:0] g;
    logic signed [RAW_W-1:0] b;
  } raw_rgb_t;

endpackage

`default_nettype wire

FILE: hdl/yuvrgb_lane.sv
// One conversion lane: forms the raw R, G, B sums of one pixel.
// Depends on yuvrgb_pkg.
`default_nettype none

module yuvrgb_lane (
  input  wire logic                         clk_i,
  input  wire logic                         en_i,
  input  wire logic [yuvrgb_pkg::BYTE_W-1:0] luma_i,
  input  wire logic signed [yuvrgb_pkg::BYTE_W-1:0] u_i,
  input  wire logic signed [yuvrgb_pkg::BYTE_W-1:0] v_i,
  output yuvrgb_pkg::raw_rgb_t              raw_o
);

  logic signed [yuvrgb_pkg::RAW_W-1:0] y_ext;
  logic signed [yuvrgb_pkg::RAW_W-1:0] u_ext;
  logic signed [yuvrgb_pkg::RAW_W-1:0] v_ext;
  logic signed [yuvrgb_pkg::RAW_W-1:0] yc;
  yuvrgb_pkg::raw_rgb_t                raw_d;
  yuvrgb_pkg::raw_rgb_t                raw_q;

  // Extend inputs to the raw sum width
  assign y_ext = yuvrgb_pkg::RAW_W'($signed({1'b0, luma_i}));
  assign u_ext = yuvrgb_pkg::RAW_W'(u_i);
  assign v_ext = yuvrgb_pkg::RAW_W'(v_i);

  // Scaled luma with rounding term, then the three channel sums
  assign yc      = yuvrgb_pkg::C_Y * (y_ext - yuvrgb_pkg::C_Y_OFS) + yuvrgb_pkg::C_ROUND;
  assign raw_d.r = yc + yuvrgb_pkg::C_RV * v_ext;
  assign raw_d.g = yc - yuvrgb_pkg::C_GU * u_ext - yuvrgb_pkg::C_GV * v_ext;
  assign raw_d.b = yc + yuvrgb_pkg::C_BU * u_ext;

  // Stage register, payload only
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      raw_q <= raw_d;
    end
  end

  assign raw_o = raw_q;

endmodule

`default_nettype wire

FILE: hdl/yuvrgb_merge.sv
// Merge stage: saturates both lanes' channels and packs the two pixel formats.
// Depends on yuvrgb_pkg.
`default_nettype none

module yuvrgb_merge (
  input  wire yuvrgb_pkg::raw_rgb_t            raw_even_i,
  input  wire yuvrgb_pkg::raw_rgb_t            raw_odd_i,
  output logic [yuvrgb_pkg::PACK_W-1:0]        packed_even_o,
  output logic [yuvrgb_pkg::PACK_W-1:0]        packed_odd_o,
  output logic [yuvrgb_pkg::WORD_W-1:0]        word565_even_o,
  output logic [yuvrgb_pkg::WORD_W-1:0]        word565_odd_o
);

  // Divide by 256 and clamp to 0..255
  function automatic logic [yuvrgb_pkg::BYTE_W-1:0] sat_channel(
    input logic signed [yuvrgb_pkg::RAW_W-1:0] raw
  );
    logic [yuvrgb_pkg::BYTE_W-1:0] res;
    if (raw[yuvrgb_pkg::RAW_W-1]) begin
      res = '0;
    end else if (|raw[yuvrgb_pkg::RAW_W-2:16]) begin
      res = '1;
    end else begin
      res = raw[15:8];
    end
    return res;
  endfunction

  logic [yuvrgb_pkg::BYTE_W-1:0] r_e, g_e, b_e;
  logic [yuvrgb_pkg::BYTE_W-1:0] r_o, g_o, b_o;

  assign r_e = sat_channel(raw_even_i.r);
  assign g_e = sat_channel(raw_even_i.g);
  assign b_e = sat_channel(raw_even_i.b);
  assign r_o = sat_channel(raw_odd_i.r);
  assign g_o = sat_channel(raw_odd_i.g);
  assign b_o = sat_channel(raw_odd_i.b);

  // B in the top byte, R in the bottom
  assign packed_even_o  = {b_e, g_e, r_e};
  assign packed_odd_o   = {b_o, g_o, r_o};
  assign word565_even_o = {b_e[7:3], g_e[7:2], r_e[7:3]};
  assign word565_odd_o  = {b_o[7:3], g_o[7:2], r_o[7:3]};

endmodule

`default_nettype wire

FILE: hdl/yuv_pixel_pair_to_rgb.sv
// Top level of the YUV pixel pair to RGB converter: two lanes and a merge stage.
// Depends on yuvrgb_pkg, yuvrgb_lane and yuvrgb_merge.
//
// Converts one horizontal pixel pair (two luma bytes sharing U and V) per
// word with BT.601 limited-range integer math, giving each pixel as packed
// 24-bit B/G/R and as 16-bit 5/6/5. A new word is taken every clock while
// in_stall_o is low. It has one stage where the two lanes form the raw channel
// sums with constant multipliers, and one output register after the merge
// stage saturates and packs. in_stall_o rises only when both stages hold
// words and the output is stalled, so a waiting result never blocks intake
// while a stage is free.
`default_nettype none

module yuv_pixel_pair_to_rgb (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  output logic                                   in_stall_o,
  input  wire logic [yuvrgb_pkg::BYTE_W-1:0]     luma_even_i,
  input  wire logic [yuvrgb_pkg::BYTE_W-1:0]     luma_odd_i,
  input  wire logic [yuvrgb_pkg::BYTE_W-1:0]     chroma_first_i,
  input  wire logic [yuvrgb_pkg::BYTE_W-1:0]     chroma_second_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output logic [yuvrgb_pkg::PACK_W-1:0]          packed_even_o,
  output logic [yuvrgb_pkg::PACK_W-1:0]          packed_odd_o,
  output logic [yuvrgb_pkg::WORD_W-1:0]          word565_even_o,
  output logic [yuvrgb_pkg::WORD_W-1:0]          word565_odd_o
);

  logic                                  s1_valid_q, s1_valid_d;
  logic                                  s2_valid_q, s2_valid_d;
  logic                                  s1_load;
  logic                                  s2_load;
  logic signed [yuvrgb_pkg::BYTE_W-1:0]  u_s;
  logic signed [yuvrgb_pkg::BYTE_W-1:0]  v_s;
  yuvrgb_pkg::raw_rgb_t                  raw_even;
  yuvrgb_pkg::raw_rgb_t                  raw_odd;
  logic [yuvrgb_pkg::PACK_W-1:0]         packed_even_d, packed_odd_d;
  logic [yuvrgb_pkg::WORD_W-1:0]         word565_even_d, word565_odd_d;
  logic [yuvrgb_pkg::PACK_W-1:0]         packed_even_q, packed_odd_q;
  logic [yuvrgb_pkg::WORD_W-1:0]         word565_even_q, word565_odd_q;

  // Pipeline flow: each stage loads when it is empty or moving on
  assign s2_load    = s1_valid_q && (!s2_valid_q || !out_stall_i);
  assign s1_load    = !s1_valid_q || s2_load;
  assign in_stall_o = !s1_load;

  assign s1_valid_d = s1_load ? in_valid_i : s1_valid_q;
  assign s2_valid_d = s2_load ? 1'b1 : (s2_valid_q && out_stall_i);

  // Chroma offset by 128 is a flip of the top bit
  assign u_s = $signed(chroma_first_i ^ 8'h80);
  assign v_s = $signed(chroma_second_i ^ 8'h80);

  // Lanes, one per pixel
  yuvrgb_lane u_lane_even (
    .clk_i  (clk_i),
    .en_i   (s1_load),
    .luma_i (luma_even_i),
    .u_i    (u_s),
    .v_i    (v_s),
    .raw_o  (raw_even)
  );

  yuvrgb_lane u_lane_odd (
    .clk_i  (clk_i),
    .en_i   (s1_load),
    .luma_i (luma_odd_i),
    .u_i    (u_s),
    .v_i    (v_s),
    .raw_o  (raw_odd)
  );

  // Saturate and pack both pixels
  yuvrgb_merge u_merge (
    .raw_even_i     (raw_even),
    .raw_odd_i      (raw_odd),
    .packed_even_o  (packed_even_d),
    .packed_odd_o   (packed_odd_d),
    .word565_even_o (word565_even_d),
    .word565_odd_o  (word565_odd_d)
  );

  // Valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
      s2_valid_q <= s2_valid_d;
    end
  end

  // Output register
  always_ff @(posedge clk_i) begin
    if (s2_load) begin
      packed_even_q  <= packed_even_d;
      packed_odd_q   <= packed_odd_d;
      word565_even_q <= word565_even_d;
      word565_odd_q  <= word565_odd_d;
    end
  end

  assign out_valid_o    = s2_valid_q;
  assign packed_even_o  = packed_even_q;
  assign packed_odd_o   = packed_odd_q;
  assign word565_even_o = word565_even_q;
  assign word565_odd_o  = word565_odd_q;

endmodule

`default_nettype wire

FILE: hdl/yuvrgb_checker.sv
// Port-level checks for yuv_pixel_pair_to_rgb, attached with a bind.
// Depends on yuvrgb_pkg and the top level's ports.
`default_nettype none

module yuvrgb_checker (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          in_valid_i,
  input wire logic                          in_stall_o,
  input wire logic                          out_valid_o,
  input wire logic                          out_stall_i,
  input wire logic [yuvrgb_pkg::PACK_W-1:0] packed_even_o,
  input wire logic [yuvrgb_pkg::PACK_W-1:0] packed_odd_o,
  input wire logic [yuvrgb_pkg::WORD_W-1:0] word565_even_o,
  input wire logic [yuvrgb_pkg::WORD_W-1:0] word565_odd_o
);

  // A stalled output word stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output word dropped while stalled");

  // Intake stalls only behind a stalled output
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_stall_i && out_valid_o)
    else $error("input stalled without output backpressure");

  // An accepted word moves from the lane stage into the output when not blocked
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o ##1 !out_stall_i |=> out_valid_o)
    else $error("accepted word did not reach the output");

  // The 5/6/5 words agree with the packed pixels
  a_formats: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |->
      word565_even_o == {packed_even_o[23:19], packed_even_o[15:10], packed_even_o[7:3]} &&
      word565_odd_o  == {packed_odd_o[23:19],  packed_odd_o[15:10],  packed_odd_o[7:3]})
    else $error("5/6/5 word does not match packed pixel");

endmodule

bind yuv_pixel_pair_to_rgb yuvrgb_checker u_yuvrgb_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_stall_o     (in_stall_o),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .packed_even_o  (packed_even_o),
  .packed_odd_o   (packed_odd_o),
  .word565_even_o (word565_even_o),
  .word565_odd_o  (word565_odd_o)
);

`default_nettype wire
